>>> rtl/i2ccds_pkg.sv
// Shared types, constants and divider ROM for the I2C clock divider search.
// No dependencies; used by i2ccds_div and i2c_clock_divider_search.
package i2ccds_pkg;

  localparam int unsigned CLOCK_W       = 32;
  localparam int unsigned ROM_ENTRIES   = 50;
  localparam int unsigned MULT_SELECTS  = 3;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned SEL_W         = 2;
  localparam int unsigned CODE_W        = 6;
  localparam int unsigned ROM_DIV_W     = 12;
  localparam int unsigned DIVISOR_W     = 14;
  localparam int unsigned BIT_CNT_W     = 5;
  localparam int unsigned RESULT_W      = 8;

  localparam logic [CLOCK_W-1:0] RATE_LIMIT_HZ = 32'd1000000;
  localparam logic [CLOCK_W-1:0] ERR_INIT      = 32'hffffffff;

  localparam logic       STATUS_OK       = 1'b0;
  localparam logic       STATUS_REJECTED = 1'b1;

  localparam logic [CODE_W-1:0] ROM_CODE [ROM_ENTRIES] = '{
    6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h09, 6'h06, 6'h0a, 6'h07,
    6'h0c, 6'h10, 6'h11, 6'h12, 6'h0f, 6'h13, 6'h14, 6'h15, 6'h19, 6'h16,
    6'h1a, 6'h17, 6'h1c, 6'h1d, 6'h1e, 6'h22, 6'h1f, 6'h23, 6'h24, 6'h25,
    6'h26, 6'h2a, 6'h27, 6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h32, 6'h2f, 6'h33,
    6'h34, 6'h35, 6'h36, 6'h3a, 6'h37, 6'h3b, 6'h3c, 6'h3d, 6'h3e, 6'h3f
  };

  localparam logic [ROM_DIV_W-1:0] ROM_DIV [ROM_ENTRIES] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,
    12'd30,   12'd32,   12'd34,   12'd36,   12'd40,
    12'd44,   12'd48,   12'd56,   12'd64,   12'd68,
    12'd72,   12'd80,   12'd88,   12'd96,   12'd104,
    12'd112,  12'd128,  12'd144,  12'd160,  12'd192,
    12'd224,  12'd240,  12'd256,  12'd288,  12'd320,
    12'd384,  12'd448,  12'd480,  12'd512,  12'd576,
    12'd640,  12'd768,  12'd896,  12'd960,  12'd1024,
    12'd1152, 12'd1280, 12'd1536, 12'd1792, 12'd1920,
    12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
  };

  typedef struct packed {
    logic                 start;
    logic [CLOCK_W-1:0]   dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [CLOCK_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/i2ccds_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, one request at a time.
// Depends on i2ccds_pkg for widths and the request/response structs.
module i2ccds_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2ccds_pkg::div_req_t req,
  output i2ccds_pkg::div_rsp_t rsp
);

  logic [i2ccds_pkg::CLOCK_W-1:0]   q_r, q_nxt;
  logic [i2ccds_pkg::DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [i2ccds_pkg::DIVISOR_W-1:0] dvs_r;
  logic [i2ccds_pkg::BIT_CNT_W-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;
  logic [i2ccds_pkg::DIVISOR_W:0]   trial;
  logic                             fits;

  always_comb begin
    trial   = {rem_r, q_r[i2ccds_pkg::CLOCK_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? i2ccds_pkg::DIVISOR_W'(trial - {1'b0, dvs_r})
                   : trial[i2ccds_pkg::DIVISOR_W-1:0];
    q_nxt   = {q_r[i2ccds_pkg::CLOCK_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divide request while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("done without a running divide");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < dvs_r)
    else $error("partial remainder not below divisor");

endmodule

>>> rtl/i2c_clock_divider_search.sv
// Top level of the I2C clock divider search: control sequencer, error compare
// and output register. Depends on i2ccds_pkg and i2ccds_div.
//
// One request carries a module clock and a target bus rate; one response
// carries the chosen divider code. Targets above 1 MHz return with status 1
// and code 0 without a scan. Otherwise 150 candidates (50 ROM dividers under
// prescale 1, 2, 4) are scanned, each in turn being issued, divided in the
// bit-serial divider, turned into an error and compared. The bit-serial
// divider is a single unit shared by all candidates. A new request is taken
// while the previous response still waits on the output.
module i2c_clock_divider_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] clock_hz, [63:32] target_hz
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] divider_code
  output logic        out_tuser   // [0] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_EVAL,
    S_FINISH
  } state_t;

  state_t                            state_r;
  logic [i2ccds_pkg::CLOCK_W-1:0]    clock_r;
  logic [i2ccds_pkg::CLOCK_W-1:0]    target_r;
  logic [i2ccds_pkg::CLOCK_W-1:0]    err_r;
  logic [i2ccds_pkg::CLOCK_W-1:0]    best_err_r;
  logic [i2ccds_pkg::SEL_W-1:0]      best_sel_r;
  logic [i2ccds_pkg::CODE_W-1:0]     best_code_r;
  logic [i2ccds_pkg::IDX_W-1:0]      idx_r;
  logic [i2ccds_pkg::SEL_W-1:0]      sel_r;
  logic                              status_r;
  logic                              out_tvalid_r;
  logic [i2ccds_pkg::RESULT_W-1:0]   out_code_r;
  logic                              out_status_r;

  i2ccds_pkg::div_req_t              div_req;
  i2ccds_pkg::div_rsp_t              div_rsp;
  logic [i2ccds_pkg::CLOCK_W-1:0]    diff;
  logic                              last_cand;
  logic                              in_accept;
  logic                              out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign last_cand = (idx_r == i2ccds_pkg::IDX_W'(i2ccds_pkg::ROM_ENTRIES - 1)) &&
                     (sel_r == i2ccds_pkg::SEL_W'(i2ccds_pkg::MULT_SELECTS - 1));

  always_comb begin
    div_req.start    = (state_r == S_START);
    div_req.dividend = clock_r;
    div_req.divisor  = {2'b00, i2ccds_pkg::ROM_DIV[idx_r]} << sel_r;
    diff = (target_r > div_rsp.quotient) ? target_r - div_rsp.quotient
                                         : div_rsp.quotient - target_r;
  end

  i2ccds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == S_FINISH && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            clock_r     <= in_tdata[31:0];
            target_r    <= in_tdata[63:32];
            best_err_r  <= i2ccds_pkg::ERR_INIT;
            best_sel_r  <= '0;
            best_code_r <= '0;
            idx_r       <= '0;
            sel_r       <= '0;
            if (in_tdata[63:32] > i2ccds_pkg::RATE_LIMIT_HZ) begin
              status_r <= i2ccds_pkg::STATUS_REJECTED;
              state_r  <= S_FINISH;
            end else begin
              status_r <= i2ccds_pkg::STATUS_OK;
              state_r  <= S_START;
            end
          end
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            err_r   <= diff;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (err_r < best_err_r) begin
            best_err_r  <= err_r;
            best_sel_r  <= sel_r;
            best_code_r <= i2ccds_pkg::ROM_CODE[idx_r];
          end
          if (last_cand) begin
            state_r <= S_FINISH;
          end else begin
            if (idx_r == i2ccds_pkg::IDX_W'(i2ccds_pkg::ROM_ENTRIES - 1)) begin
              idx_r <= '0;
              sel_r <= sel_r + 1'b1;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
            state_r <= S_START;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_status_r <= status_r;
            out_code_r   <= (status_r == i2ccds_pkg::STATUS_REJECTED) ? '0
                            : {best_sel_r, best_code_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_code_r;
  assign out_tuser  = out_status_r;

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r != S_IDLE)
    else $error("request accepted but sequencer idle");

  a_reject_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_status_r |-> out_code_r == '0)
    else $error("rejected response with nonzero code");

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_code_r[7:6] != 2'b11)
    else $error("multiplier select out of range");

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_START |-> !div_rsp.busy)
    else $error("candidate issued while divider busy");

endmodule

>>> dv/tb_top.sv
// Testbench for i2c_clock_divider_search: directed and random requests, with
// random stalls on both sides, checked against an in-bench divider search.
// Depends on i2ccds_pkg and the RTL of i2c_clock_divider_search.
module tb_top;

  localparam logic [31:0] MAX_TARGET_HZ = 32'd1000000;
  localparam int unsigned TABLE_SIZE    = 50;
  localparam int unsigned NUM_PRESCALES = 3;

  localparam logic [5:0] SCL_CODE [TABLE_SIZE] = '{
    6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h09, 6'h06, 6'h0a, 6'h07,
    6'h0c, 6'h10, 6'h11, 6'h12, 6'h0f, 6'h13, 6'h14, 6'h15, 6'h19, 6'h16,
    6'h1a, 6'h17, 6'h1c, 6'h1d, 6'h1e, 6'h22, 6'h1f, 6'h23, 6'h24, 6'h25,
    6'h26, 6'h2a, 6'h27, 6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h32, 6'h2f, 6'h33,
    6'h34, 6'h35, 6'h36, 6'h3a, 6'h37, 6'h3b, 6'h3c, 6'h3d, 6'h3e, 6'h3f
  };

  localparam logic [31:0] SCL_DIV [TABLE_SIZE] = '{
    32'd20,   32'd22,   32'd24,   32'd26,   32'd28,
    32'd30,   32'd32,   32'd34,   32'd36,   32'd40,
    32'd44,   32'd48,   32'd56,   32'd64,   32'd68,
    32'd72,   32'd80,   32'd88,   32'd96,   32'd104,
    32'd112,  32'd128,  32'd144,  32'd160,  32'd192,
    32'd224,  32'd240,  32'd256,  32'd288,  32'd320,
    32'd384,  32'd448,  32'd480,  32'd512,  32'd576,
    32'd640,  32'd768,  32'd896,  32'd960,  32'd1024,
    32'd1152, 32'd1280, 32'd1536, 32'd1792, 32'd1920,
    32'd2048, 32'd2304, 32'd2560, 32'd3072, 32'd3840
  };

  typedef struct packed {
    logic       status;
    logic [7:0] code;
  } divider_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] clock_hz, [63:32] target_hz
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] divider_code
  logic        out_tuser;  // [0] status

  divider_result_t pending_codes [$];
  int unsigned     mismatches = 0;
  bit              no_idle = 1'b0;
  int unsigned     rx_hold_cycles = 0;

  i2c_clock_divider_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic divider_result_t pick_divider(input logic [31:0] clk_hz,
                                                   input logic [31:0] tgt_hz);
    divider_result_t res;
    logic [31:0]     best_err;
    logic [31:0]     divisor;
    logic [31:0]     rate;
    logic [31:0]     err;
    res.status = i2ccds_pkg::STATUS_OK;
    res.code   = 8'd0;
    if (tgt_hz > MAX_TARGET_HZ) begin
      res.status = i2ccds_pkg::STATUS_REJECTED;
      return res;
    end
    best_err = 32'hffffffff;
    for (int sel = 0; sel < NUM_PRESCALES; sel++) begin
      for (int k = 0; k < TABLE_SIZE; k++) begin
        divisor = SCL_DIV[k] << sel;
        rate    = clk_hz / divisor;
        err     = (tgt_hz > rate) ? (tgt_hz - rate) : (rate - tgt_hz);
        if (err < best_err) begin
          best_err = err;
          res.code = {sel[1:0], SCL_CODE[k]};
        end
      end
    end
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, 18);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [31:0] clk_hz, input logic [31:0] tgt_hz);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tgt_hz, clk_hz};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_codes.push_back(pick_divider(clk_hz, tgt_hz));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_codes.size() != 0) @(negedge clk);
  endtask

  task automatic test_limits();
    send_request(32'd0, 32'd0);
    send_request(32'd0, MAX_TARGET_HZ);
    send_request(32'd1, 32'd1);
    send_request(32'd48000000, MAX_TARGET_HZ);
    send_request(32'd48000000, MAX_TARGET_HZ + 32'd1);
    send_request(32'hffffffff, 32'hffffffff);
    send_request(32'd0, 32'h80000000);
    send_request(32'hffffffff, 32'd0);
    send_request(32'hffffffff, MAX_TARGET_HZ);
    send_request(32'd100, 32'd0);
    wait_for_results();
  endtask

  task automatic test_exact_and_ties();
    send_request(32'd48000000, 32'd100000);
    send_request(32'd40000, 32'd1000);
    send_request(32'd15360, 32'd1);
    send_request(32'd24000000, 32'd400000);
    send_request(32'd24000000, 32'd100000);
    send_request(32'd20971520, 32'd400000);
    send_request(32'd8000000, 32'd1000000);
    send_request(32'd200000000, 32'd10000);
    wait_for_results();
  endtask

  task automatic test_random_requests(input int unsigned count);
    logic [31:0] clk_hz;
    logic [31:0] tgt_hz;
    int unsigned idx;
    for (int n = 0; n < count; n++) begin
      no_idle = (n < 20);
      if ($urandom_range(0, 3) == 0) begin
        tgt_hz = $urandom_range(MAX_TARGET_HZ + 32'd1, 32'hffffffff);
        clk_hz = $urandom;
      end else begin
        case ($urandom_range(0, 2))
          0: tgt_hz = $urandom_range(0, MAX_TARGET_HZ);
          1: tgt_hz = $urandom_range(0, 1000);
          default: tgt_hz = ($urandom_range(0, 1) == 0) ? 32'd100000 : 32'd400000;
        endcase
        case ($urandom_range(0, 3))
          0: clk_hz = $urandom;
          1: clk_hz = $urandom_range(1000000, 200000000);
          2: clk_hz = $urandom_range(0, 100000);
          default: begin
            idx    = $urandom_range(0, TABLE_SIZE - 1);
            tgt_hz = $urandom_range(0, 50000);
            clk_hz = (tgt_hz * SCL_DIV[idx]) << $urandom_range(0, NUM_PRESCALES - 1);
          end
        endcase
      end
      send_request(clk_hz, tgt_hz);
    end
    no_idle = 1'b0;
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    no_idle = 1'b1;
    rx_hold_cycles = 600;
    for (int n = 0; n < 8; n++)
      send_request($urandom, $urandom_range(MAX_TARGET_HZ + 32'd1, 32'hffffffff));
    send_request(32'd50000000, 32'd400000);
    send_request(32'd3000000, 32'd1);
    no_idle = 1'b0;
    wait_for_results();
  endtask

  initial begin
    int unsigned gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = draw_gap();
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    divider_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected response, status %0d code %0h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        exp_res = pending_codes.pop_front();
        if (out_tuser !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, exp_res.status, out_tuser);
          mismatches++;
        end
        if (out_tdata !== exp_res.code) begin
          $display("%0t: divider_code mismatch, expected %0h, actual %0h",
                   $time, exp_res.code, out_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 64'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_limits();
    test_exact_and_ties();
    test_random_requests(95);
    test_output_backpressure();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_codes.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

endmodule
